>>> hw/rtl/bafs_pkg.sv
// Shared constants, command codes and the queued word type of the bit-addressed field store.
`timescale 1ns / 1ps
package bafs_pkg;

  localparam int BUF_BYTES  = 4096;
  localparam int WORDS      = (BUF_BYTES + 7) / 8;
  localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TOTAL_BITS = BUF_BYTES * 8;
  localparam int MAX_FIELD  = 64;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  typedef struct packed {
    logic          err;
    logic          walk;
    logic          is_read;
    logic          is_fill;
    logic          fill_level;
    logic [AW-1:0] first;
    logic [AW-1:0] last;
    logic [5:0]    soff;
    logic [5:0]    eoff;
    logic [6:0]    sh;
    logic [63:0]   wmask;
    logic [127:0]  data;
  } bafs_item_t;

endpackage

>>> hw/rtl/bafs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bafs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bafs_front.sv
// Front end: accepts command words, checks their range, works out word spans and queues them.
`timescale 1ns / 1ps
module bafs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            command,
  input  logic [14:0]           bit_position,
  input  logic [6:0]            field_width,
  input  logic [63:0]           field_value,
  input  logic [15:0]           run_length,
  input  logic                  fill_level,
  input  logic                  clearing,
  output logic                  q_valid,
  output bafs_pkg::bafs_item_t  q_item,
  input  logic                  q_pop
);

  bafs_pkg::bafs_item_t item;
  bafs_pkg::bafs_item_t q [2];
  logic [1:0]  cnt;
  logic        wp;
  logic        rp;
  logic        push;
  logic [16:0] end_w;
  logic [16:0] end_r;
  logic [16:0] end_sel;
  logic [16:0] last_bit;
  logic        is_field;
  logic        err_w;
  logic        err_r;
  logic [7:0]  sh_wide;

  always_comb begin
    end_w    = 17'(bit_position) + 17'(field_width);
    end_r    = 17'(bit_position) + 17'(run_length);
    is_field = (command == bafs_pkg::CMD_WRITE) || (command == bafs_pkg::CMD_READ);
    err_w    = (field_width > 7'(bafs_pkg::MAX_FIELD)) ||
               (32'(end_w) > 32'(bafs_pkg::TOTAL_BITS));
    err_r    = 32'(end_r) > 32'(bafs_pkg::TOTAL_BITS);
    end_sel  = is_field ? end_w : end_r;
    last_bit = end_sel - 17'd1;
    sh_wide  = 8'd128 - 8'(bit_position[5:0]) - 8'(field_width);

    item            = '0;
    item.is_read    = command == bafs_pkg::CMD_READ;
    item.is_fill    = command == bafs_pkg::CMD_FILL;
    item.fill_level = fill_level;
    item.first      = bafs_pkg::AW'(bit_position >> 6);
    item.last       = bafs_pkg::AW'(last_bit >> 6);
    item.soff       = bit_position[5:0];
    item.eoff       = last_bit[5:0];
    item.sh         = sh_wide[6:0];
    item.wmask      = (field_width == 7'd0) ? 64'd0 : ((~64'd0) >> (7'd64 - field_width));
    item.data       = {64'd0, field_value & item.wmask} << item.sh;
    if (is_field) begin
      item.err  = err_w;
      item.walk = !err_w && (field_width != 7'd0);
    end else if (command == bafs_pkg::CMD_FILL) begin
      item.err  = err_r;
      item.walk = !err_r && (run_length != 16'd0);
    end
  end

  assign in_stall = clearing || (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt != 2'd0;
  assign q_item   = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (q_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> hw/rtl/bafs_back.sv
// Back end: clears the store after reset, then reads or read-modify-writes 64-bit words per queued command.
`timescale 1ns / 1ps
module bafs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  bafs_pkg::bafs_item_t          q_item,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          ram_we,
  output logic [bafs_pkg::AW-1:0]       ram_waddr,
  output logic [63:0]                   ram_wdata,
  output logic [bafs_pkg::AW-1:0]       ram_raddr,
  input  logic [63:0]                   ram_rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [63:0]                   read_value,
  output logic                          range_error
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MERGE,
    ST_DONE
  } state_t;

  state_t               state;
  bafs_pkg::bafs_item_t it;
  logic [bafs_pkg::AW-1:0] cur;
  logic [63:0]          hold;
  logic [63:0]          res_rd;
  logic                 res_err;
  logic [5:0]           lo;
  logic [5:0]           hi;
  logic [63:0]          mask;
  logic [63:0]          wsrc;
  logic [127:0]         window;
  logic [63:0]          rd_calc;

  always_comb begin
    lo      = (cur == it.first) ? it.soff : 6'd0;
    hi      = (cur == it.last) ? it.eoff : 6'd63;
    mask    = ((~64'd0) >> lo) & ((~64'd0) << (6'd63 - hi));
    wsrc    = it.is_fill ? {64{it.fill_level}} :
              ((cur == it.first) ? it.data[127:64] : it.data[63:0]);
    window  = (it.first == it.last) ? {ram_rdata, 64'd0} : {hold, ram_rdata};
    rd_calc = 64'(window >> it.sh) & it.wmask;

    clearing  = state == ST_CLEAR;
    q_pop     = (state == ST_IDLE) && q_valid;
    ram_raddr = cur;
    ram_waddr = cur;
    ram_we    = 1'b0;
    ram_wdata = 64'd0;
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == ST_MERGE && !it.is_read) begin
      ram_we    = 1'b1;
      ram_wdata = (ram_rdata & ~mask) | (wsrc & mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cur       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          cur <= cur + bafs_pkg::AW'(1);
          if (cur == bafs_pkg::AW'(bafs_pkg::WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            it      <= q_item;
            cur     <= q_item.first;
            res_rd  <= 64'd0;
            res_err <= q_item.err;
            state   <= q_item.walk ? ST_READ : ST_DONE;
          end
        end
        ST_READ: begin
          state <= ST_MERGE;
        end
        ST_MERGE: begin
          hold <= ram_rdata;
          if (cur == it.last) begin
            if (it.is_read) begin
              res_rd <= rd_calc;
            end
            state <= ST_DONE;
          end else begin
            cur   <= cur + bafs_pkg::AW'(1);
            state <= ST_READ;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            read_value  <= res_rd;
            range_error <= res_err;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/bit_addressed_field_store_core.sv
// Top level of the bit-addressed field store: front end, command queue, back end and word RAM.
`timescale 1ns / 1ps
// The store holds BUF_BYTES bytes addressed by bit, bit 0 being the most significant bit of
// byte 0, kept in a simple dual-port RAM of 64-bit words. Every input word yields exactly one
// output word. After reset the block zeroes the store, writing each RAM word in turn (512 words
// for 4096 bytes), and holds in_stall high throughout. A command that touches no memory (range
// error, zero length or the unused code) goes straight to the done state in the back end; a
// field access spans one or two 64-bit words, and a fill run up to 512 words. Each spanned word
// is read in ST_READ and merged in ST_MERGE, which writes it back unless the command is a read,
// since the word RAM's read data arrives in the cycle after the address. A two-deep queue lets
// the front end keep taking words while the back end works, and the result register lets the
// next command start while a finished result waits on out_stall.
module bit_addressed_field_store_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [14:0] bit_position,
  input  logic [6:0]  field_width,
  input  logic [63:0] field_value,
  input  logic [15:0] run_length,
  input  logic        fill_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] read_value,
  output logic        range_error
);

  // Classified commands travel from front to back through this queue.
  logic                         q_valid;
  logic                         q_pop;
  bafs_pkg::bafs_item_t         q_item;
  logic                         clearing;
  logic                         ram_we;
  logic [bafs_pkg::AW-1:0]      ram_waddr;
  logic [bafs_pkg::AW-1:0]      ram_raddr;
  logic [63:0]                  ram_wdata;
  logic [63:0]                  ram_rdata;

  bafs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .bit_position (bit_position),
    .field_width  (field_width),
    .field_value  (field_value),
    .run_length   (run_length),
    .fill_level   (fill_level),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  bafs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .range_error (range_error)
  );

  // The store itself: 64-bit words, bit 63 of a word is the first bit in address order.
  bafs_ram #(
    .WIDTH (64),
    .DEPTH (bafs_pkg::WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> hw/rtl/bafs_checker.sv
// Port-level checks on the bit-addressed field store, bound to its top level.
`timescale 1ns / 1ps
module bafs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  command,
  input logic [14:0] bit_position,
  input logic [6:0]  field_width,
  input logic [63:0] field_value,
  input logic [15:0] run_length,
  input logic        fill_level,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] read_value,
  input logic        range_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(read_value) && $stable(range_error))
    else $error("stalled result word changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> read_value == 64'd0)
    else $error("refused access returned a value");

  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall && !out_valid)
    else $error("input taken or result shown during the clearing pass");

endmodule

bind bit_addressed_field_store_core bafs_checker u_bafs_checker (.*);
